// ===== rtl/core/wave_stencil_2nd_time_10th_space_unit_defines.svh =====
// Assertion macros shared by the wave stencil RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef WAVE_STENCIL_2ND_TIME_10TH_SPACE_UNIT_DEFINES_SVH
`define WAVE_STENCIL_2ND_TIME_10TH_SPACE_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define WSU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define WSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wsu_pkg.sv =====
// Shared types, widths and coefficient table for the wave stencil unit.
// No dependencies.
package wsu_pkg;

   localparam int DEFAULT_MAX_ROW_LEN = 1024;
   localparam int MIN_DIM    = 11;
   localparam int RADIUS     = 5;
   localparam int SAMPLE_W   = 32;
   localparam int VEL_W      = 24;
   localparam int ROW_W      = 16;
   localparam int LEN_REG_W  = 11;
   localparam int REQ_DATA_W = 2 * SAMPLE_W + VEL_W;
   localparam int SUM_W      = SAMPLE_W + 2;
   localparam int LAP_W      = 40;
   localparam int RES_W      = 42;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 21;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int WIDE_W     = 68;
   localparam int SPLIT_S    = 17;
   localparam int SPLIT_L    = 20;
   localparam int Q30_SHIFT  = 30;
   localparam int Q24_SHIFT  = 24;
   localparam int TERM_W     = 3;

   localparam logic REG_ROW_LENGTH = 1'b0;
   localparam logic REG_ROW_COUNT  = 1'b1;

   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_S_HI = 2'd0;
   localparam mul_sel_type MUL_S_LO = 2'd1;
   localparam mul_sel_type MUL_V_HI = 2'd2;
   localparam mul_sel_type MUL_V_LO = 2'd3;

   typedef struct packed {
      logic              lap_clr;
      logic              s_first;
      logic              s_second;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              acc;
      logic              d_load;
      logic [TERM_W-1:0] term;
   } mac_ctrl_type;

   // Q2.30 stencil weights; term 0 is the center weight, subtracted from the sum
   function automatic logic signed [SAMPLE_W-1:0] coef_at(input logic [TERM_W-1:0] k);
      logic signed [SAMPLE_W-1:0] c;
      case (k)
         3'd0:    c = 32'sd1571540465;
         3'd1:    c = 32'sd1789569707;
         3'd2:    c = -32'sd255652815;
         3'd3:    c = 32'sd42608803;
         3'd4:    c = -32'sd5326100;
         3'd5:    c = 32'sd340870;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/wsu_mac.sv =====
// Stencil arithmetic: neighbor sums, shared multiplier, Laplacian accumulator,
// velocity scaling and saturation. Depends on wsu_pkg.
module wsu_mac
   import wsu_pkg::*;
(
   input  logic                       clock,
   input  mac_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] rd_a,
   input  logic signed [SAMPLE_W-1:0] rd_b,
   input  logic        [VEL_W-1:0]    vel,
   input  logic signed [SAMPLE_W-1:0] prev,
   output logic signed [SAMPLE_W-1:0] new_sample,
   output logic                       saturated
);

   logic signed [SUM_W-2:0]  s_part_ff, s_part_in;
   logic signed [SUM_W-1:0]  s_ff, s_in;
   logic signed [SAMPLE_W-1:0] c_ff;
   logic signed [PROD_W-1:0] hi_ff, lo_ff, prod;
   logic signed [LAP_W-1:0]  lap_ff, lap_in, d_ff, d_in, term_q;
   logic signed [MUL_A_W-1:0] mul_x;
   logic signed [MUL_B_W-1:0] mul_y;
   logic signed [WIDE_W-1:0] hi_ext, lo_ext, rnd_q30, rnd_q24, term_wide, d_wide;
   logic signed [RES_W-1:0]  res, res_max, res_min;

   assign rnd_q30 = 68'sd1 <<< (Q30_SHIFT - 1);
   assign rnd_q24 = 68'sd1 <<< (Q24_SHIFT - 1);
   assign res_max = 42'sd2147483647;
   assign res_min = -42'sd2147483648;

   always_comb begin
      case (ctrl.mul_sel)
         MUL_S_HI: begin
            mul_x = MUL_A_W'(coef_at(ctrl.term));
            mul_y = MUL_B_W'(s_ff >>> SPLIT_S);
         end
         MUL_S_LO: begin
            mul_x = MUL_A_W'(coef_at(ctrl.term));
            mul_y = $signed({{(MUL_B_W-SPLIT_S){1'b0}}, s_ff[SPLIT_S-1:0]});
         end
         MUL_V_HI: begin
            mul_x = $signed({{(MUL_A_W-VEL_W){1'b0}}, vel});
            mul_y = MUL_B_W'(lap_ff >>> SPLIT_L);
         end
         default: begin
            mul_x = $signed({{(MUL_A_W-VEL_W){1'b0}}, vel});
            mul_y = $signed({{(MUL_B_W-SPLIT_L){1'b0}}, lap_ff[SPLIT_L-1:0]});
         end
      endcase
   end

   assign prod      = PROD_W'(mul_x) * PROD_W'(mul_y);
   assign hi_ext    = WIDE_W'(hi_ff);
   assign lo_ext    = WIDE_W'(lo_ff);
   assign term_wide = (hi_ext <<< SPLIT_S) + lo_ext + rnd_q30;
   assign d_wide    = (hi_ext <<< SPLIT_L) + lo_ext + rnd_q24;
   assign term_q    = LAP_W'(term_wide >>> Q30_SHIFT);
   assign lap_in    = ctrl.lap_clr ? '0 :
                      (ctrl.term == '0) ? lap_ff - term_q : lap_ff + term_q;
   assign d_in      = LAP_W'(d_wide >>> Q24_SHIFT);
   assign s_part_in = (SUM_W-1)'(rd_a) + (SUM_W-1)'(rd_b);
   assign s_in      = SUM_W'(s_part_ff) + SUM_W'(rd_a) + SUM_W'(rd_b);

   always_ff @(posedge clock) begin
      if (ctrl.s_first) begin
         s_part_ff <= s_part_in;
         if (ctrl.term == '0) begin
            c_ff <= rd_a;
         end
      end
      if (ctrl.s_second) begin
         s_ff <= s_in;
      end
      if (ctrl.mul_en) begin
         if (ctrl.mul_sel == MUL_S_HI || ctrl.mul_sel == MUL_V_HI) begin
            hi_ff <= prod;
         end else begin
            lo_ff <= prod;
         end
      end
      if (ctrl.acc || ctrl.lap_clr) begin
         lap_ff <= lap_in;
      end
      if (ctrl.d_load) begin
         d_ff <= d_in;
      end
   end

   assign res = (RES_W'(c_ff) <<< 1) - RES_W'(prev) + RES_W'(d_ff);

   always_comb begin
      saturated = 1'b0;
      new_sample = SAMPLE_W'(res);
      if (res > res_max) begin
         new_sample = SAMPLE_W'(res_max);
         saturated = 1'b1;
      end else if (res < res_min) begin
         new_sample = SAMPLE_W'(res_min);
         saturated = 1'b1;
      end
   end

endmodule

// ===== rtl/core/wave_stencil_2nd_time_10th_space_unit.sv =====
// One time step of the 2-D acoustic wave equation, 10th order cross stencil.
// Depends on wsu_pkg, wsu_mac and the assertion macro header.
//
// Grid points enter in raster order; the updated value of a point leaves
// 5*row_length+5 requests after it entered, and points within five rows or
// columns of an edge return their previous sample. A request that produces
// no result returns to idle after its tap check; one that produces a result
// is paced by the single shared 33x21 multiplier (two passes for each of six
// stencil terms plus two for the velocity scaling) and by the two read ports
// of the line buffer memory, which deliver the 21 stencil samples two per
// cycle, and its final step waits while the previous result is unread.
// The line buffers need no clearing pass after reset. A finished result waits
// in an output register, so the next request is taken while it is unread.
// A drain request (tuser set) advances the pipeline to flush a frame.
// Register writes are taken only between requests.
`include "wave_stencil_2nd_time_10th_space_unit_defines.svh"
module wave_stencil_2nd_time_10th_space_unit
   import wsu_pkg::*;
#(
   parameter int MAX_ROW_LEN = DEFAULT_MAX_ROW_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // curr_sample, prev_sample, vel_factor
   input  logic                  req_tuser,  // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,  // new_sample
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,  // saturated
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [ROW_W-1:0]      csr_data
);

   localparam int RING = 2 * RADIUS * MAX_ROW_LEN + 2 * RADIUS + 1;
   localparam int RW   = $clog2(RING);
   localparam int LW   = $clog2(MAX_ROW_LEN + 1);
   localparam int CW   = $clog2(MAX_ROW_LEN);
   localparam int CMPW = (LW > LEN_REG_W) ? LW : LEN_REG_W;
   localparam int SIDE_W = 1 + VEL_W + SAMPLE_W;
   localparam logic [RW:0] RING_EXT = (RW+1)'(RING);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD1  = 4'd1;
   localparam logic [3:0] ST_RD2  = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_MHI  = 4'd4;
   localparam logic [3:0] ST_MLO  = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_VHI  = 4'd7;
   localparam logic [3:0] ST_VLO  = 4'd8;
   localparam logic [3:0] ST_DFIN = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   function automatic logic [RW-1:0] ring_sub(input logic [RW-1:0] b, input logic [RW-1:0] o);
      logic [RW:0] diff;
      diff = {1'b0, b} - {1'b0, o};
      if (diff[RW]) begin
         diff = diff + RING_EXT;
      end
      return diff[RW-1:0];
   endfunction

   logic [3:0]           state_ff, state_in;
   logic [RW-1:0]        wr_ptr_ff, wr_ptr_in, wr_next;
   logic [RW-1:0]        items_ff, items_in;
   logic                 ok_ff, ok_in;
   logic [RW-1:0]        base_ff, base_in;
   logic [TERM_W-1:0]    term_ff, term_in;
   logic [RW-1:0]        klen_ff, klen_in;
   logic [CW-1:0]        out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [LEN_REG_W-1:0] row_length_ff, row_length_in;
   logic [ROW_W-1:0]     row_count_ff, row_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff;
   logic                 rsp_last_ff, rsp_sat_ff, rsp_load;

   logic [CMPW-1:0]      len_raw;
   logic [LW-1:0]        len;
   logic [ROW_W-1:0]     rows;
   logic [RW-1:0]        dly, off_a, off_b, addr_a, addr_b, tap;
   logic                 accept, csr_accept, rd_en, interior, last_pt, col_end;

   logic signed [SAMPLE_W-1:0] cur_mem [RING];
   logic        [SIDE_W-1:0]   side_mem [RING];
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic        [SIDE_W-1:0]   side_rd_ff;
   logic                       side_point, side_clr, side_we;
   logic        [RW-1:0]       side_wa;
   logic        [SIDE_W-1:0]   side_wd;
   logic        [VEL_W-1:0]    side_vel;
   logic signed [SAMPLE_W-1:0] side_prev, mac_sample;
   logic                       mac_sat;
   mac_ctrl_type               ctrl;

   assign len_raw = CMPW'(row_length_ff);
   always_comb begin
      if (len_raw < CMPW'(MIN_DIM)) begin
         len = LW'(MIN_DIM);
      end else if (len_raw > CMPW'(MAX_ROW_LEN)) begin
         len = LW'(MAX_ROW_LEN);
      end else begin
         len = LW'(len_raw);
      end
   end
   assign rows = (row_count_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : row_count_ff;
   assign dly  = RW'(len) * RW'(RADIUS) + RW'(RADIUS);

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_accept = csr_valid && csr_ready;
   assign wr_next    = (wr_ptr_ff == RW'(RING - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign tap        = ring_sub(wr_next, dly);
   assign addr_a     = ring_sub(base_ff, off_a);
   assign addr_b     = ring_sub(base_ff, off_b);

   assign side_point = side_rd_ff[SIDE_W-1];
   assign side_vel   = side_rd_ff[SAMPLE_W +: VEL_W];
   assign side_prev  = $signed(side_rd_ff[SAMPLE_W-1:0]);

   assign interior = (out_row_ff >= ROW_W'(RADIUS))
                  && ((ROW_W+1)'(out_row_ff) + (ROW_W+1)'(RADIUS) < (ROW_W+1)'(rows))
                  && (out_col_ff >= CW'(RADIUS))
                  && ((LW+1)'(out_col_ff) + (LW+1)'(RADIUS) < (LW+1)'(len));
   assign col_end  = ((LW+1)'(out_col_ff) + (LW+1)'(1) >= (LW+1)'(len));
   assign last_pt  = col_end && ((ROW_W+1)'(out_row_ff) + (ROW_W+1)'(1) >= (ROW_W+1)'(rows));

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      items_in      = items_ff;
      ok_in         = ok_ff;
      base_in       = base_ff;
      term_in       = term_ff;
      klen_in       = klen_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_load      = 1'b0;
      rd_en         = 1'b0;
      side_clr      = 1'b0;
      off_a         = dly;
      off_b         = dly;
      ctrl          = '0;
      ctrl.term     = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               wr_ptr_in    = wr_next;
               base_in      = wr_next;
               ok_in        = (items_ff >= dly);
               items_in     = (items_ff == RW'(RING - 1)) ? items_ff : items_ff + 1'b1;
               term_in      = '0;
               klen_in      = '0;
               ctrl.lap_clr = 1'b1;
               state_in     = ST_RD1;
            end
         end
         ST_RD1: begin
            if (term_ff == '0 && !(ok_ff && side_point)) begin
               state_in = ST_IDLE;
            end else begin
               // tap entry is emitted once: clear its point flag
               side_clr = (term_ff == '0);
               rd_en    = 1'b1;
               off_a    = dly - RW'(term_ff);
               off_b    = dly + RW'(term_ff);
               state_in = ST_RD2;
            end
         end
         ST_RD2: begin
            ctrl.s_first = 1'b1;
            rd_en        = 1'b1;
            off_a        = dly - klen_ff;
            off_b        = dly + klen_ff;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            ctrl.s_second = 1'b1;
            state_in      = ST_MHI;
         end
         ST_MHI: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_S_HI;
            state_in     = ST_MLO;
         end
         ST_MLO: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_S_LO;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            ctrl.acc = 1'b1;
            if (term_ff == TERM_W'(RADIUS)) begin
               state_in = ST_VHI;
            end else begin
               term_in  = term_ff + 1'b1;
               klen_in  = klen_ff + RW'(len);
               state_in = ST_RD1;
            end
         end
         ST_VHI: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_V_HI;
            state_in     = ST_VLO;
         end
         ST_VLO: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_V_LO;
            state_in     = ST_DFIN;
         end
         ST_DFIN: begin
            ctrl.d_load = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (col_end) begin
                  out_col_in = '0;
                  out_row_in = last_pt ? '0 : out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_accept) begin
         unique case (csr_index)
            REG_ROW_LENGTH: row_length_in = csr_data[LEN_REG_W-1:0];
            REG_ROW_COUNT:  row_count_in  = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         items_ff      <= '0;
         ok_ff         <= 1'b0;
         base_ff       <= '0;
         term_ff       <= '0;
         klen_ff       <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         row_length_ff <= LEN_REG_W'(1024);
         row_count_ff  <= ROW_W'(1024);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         items_ff      <= items_in;
         ok_ff         <= ok_in;
         base_ff       <= base_in;
         term_ff       <= term_in;
         klen_ff       <= klen_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= interior ? mac_sample : side_prev;
         rsp_sat_ff  <= interior && mac_sat;
         rsp_last_ff <= last_pt;
      end
   end

   assign side_we = accept || side_clr;
   assign side_wa = accept ? wr_next : addr_a;
   assign side_wd = accept ? {!req_tuser, req_tdata[2*SAMPLE_W +: VEL_W],
                              req_tdata[SAMPLE_W +: SAMPLE_W]}
                           : {1'b0, side_rd_ff[SIDE_W-2:0]};

   // line buffers: current samples on two read ports, previous/velocity at the tap
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_mem[wr_next]  <= req_tuser ? '0 : $signed(req_tdata[SAMPLE_W-1:0]);
         side_rd_ff        <= side_mem[tap];
      end
      if (side_we) begin
         side_mem[side_wa] <= side_wd;
      end
      if (rd_en) begin
         rd_a_ff <= cur_mem[addr_a];
         rd_b_ff <= cur_mem[addr_b];
      end
   end

   wsu_mac u_mac (
      .clock      (clock),
      .ctrl       (ctrl),
      .rd_a       (rd_a_ff),
      .rd_b       (rd_b_ff),
      .vel        (side_vel),
      .prev       (side_prev),
      .new_sample (mac_sample),
      .saturated  (mac_sat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `WSU_ASSERT_ALWAYS(a_wr_ptr_range, clock, reset, wr_ptr_ff < RW'(RING), "write pointer out of ring")
   `WSU_ASSERT_NEXT(a_wr_ptr_step, clock, reset, accept, wr_ptr_ff != $past(wr_ptr_ff), "pointer stuck")
   `WSU_ASSERT_ALWAYS(a_term_range, clock, reset, term_ff <= TERM_W'(RADIUS), "stencil term overrun")
   `WSU_ASSERT_NEXT(a_rsp_load, clock, reset, rsp_load, rsp_tvalid, "result lost at output register")

endmodule
